// File: src/door_cycle_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Door cycle sequencer assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DOOR_CYCLE_SEQUENCER_DEFINES_SVH
`define DOOR_CYCLE_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

// File: src/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Widths, register indexes, reset values and the stepper coil table.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DUTY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DUTY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE_STEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_TICKS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd7;

    localparam logic [7:0]  RST_TEMP_LOW     = 8'd93;
    localparam logic [7:0]  RST_TEMP_HIGH    = 8'd197;
    localparam logic [7:0]  RST_OPEN_DUTY    = 8'h1A;
    localparam logic [7:0]  RST_CLOSE_DUTY   = 8'h40;
    localparam logic [9:0]  RST_HANDLE_STEPS = 10'd350;
    localparam logic [15:0] RST_STEP_TICKS   = 16'd25;
    localparam logic [15:0] RST_DRIVE_TICKS  = 16'd2000;
    localparam logic [15:0] RST_HOLD_TICKS   = 16'd8000;

    // Wave-drive position to coil pattern: 1a, 2b, 1b, 2a.
    function automatic logic [3:0] coil_of(input logic [1:0] pos);
        logic [3:0] pattern;
        case (pos)
            2'd0:    pattern = 4'h8;
            2'd1:    pattern = 4'h1;
            2'd2:    pattern = 4'h4;
            default: pattern = 4'h2;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

// File: src/door_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// door_cycle_sequencer
// Badge-triggered door cycle: handle stepper, door motor and hold timing.
// ----------------------------------------------------------------------------
// Usage:
//   One beat on the s_ channel per 1 ms tick carries both badge inputs, the
//   lock pin and a temperature sample. Each accepted beat produces exactly one
//   beat on the m_ channel with the coil pattern, motor controls, status flags
//   and the cycle phase after that tick.
//   The result of a beat accepted at one edge is registered and valid on
//   m_tdata after that edge. A beat is accepted every cycle while results are
//   taken; the whole tick update is one pass through the phase logic between
//   the state registers and the result register.
//   The cfg_ channel writes the eight timing and threshold registers by index
//   and is always ready; write only while no result is pending.
//   At reset the block is idle, all coils are off and the registers take their
//   default values; no result is pending.
//   When the receiver stalls, the result register holds its beat and s_tready
//   drops until that beat is taken; a new beat is taken in the same cycle as
//   the old result leaves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "door_cycle_sequencer_defines.svh"

module door_cycle_sequencer
    import dcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: badge_outside, badge_inside, lock_released,
    // temp_sample[7:0], zero fill.
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: coil_drive[3:0], motor_forward, motor_reverse,
    // motor_duty[7:0], busy_res, temp_ok, lock_wait, cycle_phase[2:0], zero fill.
    output logic [M_DATA_W-1:0]        m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_OPEN  = 3'd1,
        PH_PUSH  = 3'd2,
        PH_HOLD  = 3'd3,
        PH_PULL  = 3'd4,
        PH_CLOSE = 3'd5
    } phase_t;

    logic [7:0]  temp_low_reg, temp_high_reg, open_duty_reg, close_duty_reg;
    logic [9:0]  handle_steps_reg;
    logic [15:0] step_ticks_reg, drive_ticks_reg, hold_ticks_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  stepper_reg, stepper_next;
    logic [3:0]  coil_reg, coil_next;
    logic [9:0]  steps_reg, steps_next;
    logic [15:0] tick_reg, tick_next;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic        s_accept;
    logic        badge_outside, badge_inside, lock_released;
    logic [7:0]  temp_sample;
    logic        temp_ok;
    logic        lock_wait;
    logic        run;
    logic [15:0] step_wait;
    logic [7:0]  duty;

    assign s_accept      = s_tvalid && s_tready;
    assign s_tready      = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign cfg_ready     = 1'b1;

    assign badge_outside = s_tdata[0];
    assign badge_inside  = s_tdata[1];
    assign lock_released = s_tdata[2];
    assign temp_sample   = s_tdata[10:3];

    assign temp_ok   = (temp_sample >= temp_low_reg) && (temp_sample <= temp_high_reg);
    assign step_wait = (step_ticks_reg == 16'd0) ? 16'd1 : step_ticks_reg;

    always_comb begin
        phase_next   = phase_reg;
        stepper_next = stepper_reg;
        coil_next    = coil_reg;
        steps_next   = steps_reg;
        tick_next    = tick_reg;
        lock_wait    = 1'b0;
        run          = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (!lock_released) begin
                lock_wait = 1'b1;
            end else if (badge_outside || (badge_inside && temp_ok)) begin
                phase_next = PH_OPEN;
                steps_next = 10'd0;
                tick_next  = 16'd0;
                run        = 1'b1;
            end
        end else begin
            if (tick_next != 16'd0) begin
                tick_next = tick_next - 16'd1;
            end
            run = (tick_next == 16'd0);
        end

        if (run && phase_next == PH_OPEN) begin
            if (steps_next < handle_steps_reg) begin
                stepper_next = stepper_next - 2'd1;
                coil_next    = coil_of(stepper_next);
                steps_next   = steps_next + 10'd1;
                tick_next    = step_wait;
            end else begin
                phase_next = PH_PUSH;
                tick_next  = drive_ticks_reg;
            end
        end
        if (run && phase_next == PH_PUSH && tick_next == 16'd0) begin
            phase_next = PH_HOLD;
            tick_next  = hold_ticks_reg;
        end
        if (run && phase_next == PH_HOLD && tick_next == 16'd0) begin
            phase_next = PH_PULL;
            tick_next  = drive_ticks_reg;
        end
        if (run && phase_next == PH_PULL && tick_next == 16'd0) begin
            phase_next = PH_CLOSE;
            steps_next = 10'd0;
        end
        if (run && phase_next == PH_CLOSE && tick_next == 16'd0) begin
            if (steps_next < handle_steps_reg) begin
                stepper_next = stepper_next + 2'd1;
                coil_next    = coil_of(stepper_next);
                steps_next   = steps_next + 10'd1;
                tick_next    = step_wait;
            end else begin
                phase_next = PH_IDLE;
                tick_next  = 16'd0;
            end
        end
        if (run && phase_next > PH_CLOSE) begin
            phase_next = PH_IDLE;
            tick_next  = 16'd0;
        end
    end

    always_comb begin
        case (phase_next)
            PH_PUSH: duty = open_duty_reg;
            PH_PULL: duty = close_duty_reg;
            default: duty = 8'd0;
        endcase
        m_tdata_next = {4'd0, phase_next, lock_wait, temp_ok, (phase_next != PH_IDLE),
                        duty, (phase_next == PH_PULL), (phase_next == PH_PUSH), coil_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_low_reg     <= RST_TEMP_LOW;
            temp_high_reg    <= RST_TEMP_HIGH;
            open_duty_reg    <= RST_OPEN_DUTY;
            close_duty_reg   <= RST_CLOSE_DUTY;
            handle_steps_reg <= RST_HANDLE_STEPS;
            step_ticks_reg   <= RST_STEP_TICKS;
            drive_ticks_reg  <= RST_DRIVE_TICKS;
            hold_ticks_reg   <= RST_HOLD_TICKS;
            phase_reg        <= PH_IDLE;
            stepper_reg      <= 2'd0;
            coil_reg         <= 4'd0;
            steps_reg        <= 10'd0;
            tick_reg         <= 16'd0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TEMP_LOW:     temp_low_reg     <= cfg_data[7:0];
                    CFG_TEMP_HIGH:    temp_high_reg    <= cfg_data[7:0];
                    CFG_OPEN_DUTY:    open_duty_reg    <= cfg_data[7:0];
                    CFG_CLOSE_DUTY:   close_duty_reg   <= cfg_data[7:0];
                    CFG_HANDLE_STEPS: handle_steps_reg <= cfg_data[9:0];
                    CFG_STEP_TICKS:   step_ticks_reg   <= cfg_data;
                    CFG_DRIVE_TICKS:  drive_ticks_reg  <= cfg_data;
                    CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                    default:          hold_ticks_reg   <= hold_ticks_reg;
                endcase
            end
            if (s_accept) begin
                phase_reg    <= phase_next;
                stepper_reg  <= stepper_next;
                coil_reg     <= coil_next;
                steps_reg    <= steps_next;
                tick_reg     <= tick_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    `DCS_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `DCS_ASSERT_SAME(a_motor_one_way, m_tvalid, !(m_tdata[4] && m_tdata[5]))
    `DCS_ASSERT_SAME(a_coil_wave, 1'b1, $onehot0(coil_reg))
    `DCS_ASSERT_SAME(a_phase_legal, 1'b1, phase_reg <= PH_CLOSE)
    `DCS_ASSERT_NEXT(a_lock_holds_idle,
        s_accept && phase_reg == PH_IDLE && !lock_released, phase_reg == PH_IDLE)

endmodule

`default_nettype wire
